/* rtl/bm3_pkg.sv */
// Package for the 3x3 box-mean filter: register and command codes, shared
// constants, and the structs passed between the pipeline stages.
// No dependencies.
package bm3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int MAX_HEIGHT  = 1024;
  localparam int HEIGHT_BITS = 10;
  localparam int MIN_SIZE    = 3;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 11;
  localparam int SIZE_BITS      = 11;
  localparam int MEAN_BITS      = 8;
  localparam int PAD_BITS       = 8;

  localparam logic [SIZE_BITS-1:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [SIZE_BITS-1:0] RST_FRAME_HEIGHT = 11'd1024;
  localparam logic                 RST_PAD_MODE     = 1'b1;
  localparam logic [PAD_BITS-1:0]  RST_PAD_VALUE    = 8'd255;

  localparam int OUT_DEPTH      = 8;
  localparam int OUT_PTR_BITS   = 3;
  localparam int OUT_COUNT_BITS = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PAD_MODE     = 2'd2,
    REG_PAD_VALUE    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic {
    PAD_CONSTANT  = 1'b0,
    PAD_REPLICATE = 1'b1
  } pad_mode_e;

  typedef struct packed {
    logic valid;
    logic flush;
    logic emit_main;
    logic emit_right;
    logic top;
    logic left;
    logic right;
    logic first;
    logic capture;
    logic eof;
  } item_ctl_t;

  typedef struct packed {
    logic                 eof;
    logic                 last;
    logic [MEAN_BITS-1:0] mean;
  } result_t;

endpackage

/* rtl/bm3_ctrl.sv */
// Configuration registers, raster position counters and flush sequencing.
// Issues line store reads and hands the item to the window stage.
// Depends on bm3_pkg.
module bm3_ctrl #(
  parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bm3_pkg::DEF_PIXEL_BITS,
  parameter int AW         = $clog2(MAX_WIDTH)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bm3_pkg::cmd_e                        in_command,
  input  logic [PIXEL_BITS-1:0]                in_pixel,
  input  logic                                 room,
  input  logic                                 cfg_write,
  input  bm3_pkg::cfg_reg_e                    cfg_index,
  input  logic [bm3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                 pad_mode,
  output logic [bm3_pkg::PAD_BITS-1:0]         pad_value,
  output logic                                 rd_en,
  output logic [AW-1:0]                        rd_addr,
  output bm3_pkg::item_ctl_t                   s1_ctl,
  output logic [AW-1:0]                        s1_addr,
  output logic [PIXEL_BITS-1:0]                s1_pix
);
  import bm3_pkg::*;

  logic [SIZE_BITS-1:0]   frame_width;
  logic [SIZE_BITS-1:0]   frame_height;
  logic [AW-1:0]          w_m1;
  logic [HEIGHT_BITS-1:0] h_m1;

  logic [AW-1:0]          col, col_next;
  logic [HEIGHT_BITS-1:0] row, row_next;
  logic [AW-1:0]          flush_col, flush_col_next;
  logic                   pending, pending_next;
  logic [AW-1:0]          cur_col;
  logic [HEIGHT_BITS-1:0] cur_row;
  item_ctl_t              ctl_next;
  logic                   accept;
  logic                   size_write;

  assign in_ready   = room;
  assign accept     = in_valid & room;
  assign size_write = cfg_write &
                      ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  always_comb begin
    if (int'(frame_width) < MIN_SIZE) begin
      w_m1 = AW'(MIN_SIZE - 1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_m1 = AW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = AW'(frame_width - 11'd1);
    end
    if (int'(frame_height) < MIN_SIZE) begin
      h_m1 = HEIGHT_BITS'(MIN_SIZE - 1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_m1 = HEIGHT_BITS'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = HEIGHT_BITS'(frame_height - 11'd1);
    end
  end

  always_comb begin
    col_next       = col;
    row_next       = row;
    flush_col_next = flush_col;
    pending_next   = pending;
    ctl_next       = '0;
    rd_en          = 1'b0;
    rd_addr        = col;
    cur_col        = pending ? '0 : col;
    cur_row        = pending ? '0 : row;
    priority if (size_write) begin
      col_next       = '0;
      row_next       = '0;
      flush_col_next = '0;
      pending_next   = 1'b0;
    end else if (accept && (in_command == CMD_FLUSH)) begin
      if (pending) begin
        rd_en               = 1'b1;
        rd_addr             = (flush_col == w_m1) ? w_m1 : flush_col + AW'(1);
        ctl_next.valid      = 1'b1;
        ctl_next.flush      = 1'b1;
        ctl_next.emit_main  = 1'b1;
        ctl_next.left       = (flush_col == '0);
        ctl_next.first      = (flush_col == '0);
        ctl_next.right      = (flush_col == w_m1);
        ctl_next.eof        = (flush_col == w_m1);
        if (flush_col == w_m1) begin
          col_next       = '0;
          row_next       = '0;
          flush_col_next = '0;
          pending_next   = 1'b0;
        end else begin
          flush_col_next = flush_col + AW'(1);
        end
      end
    end else if (accept) begin
      rd_en               = 1'b1;
      rd_addr             = cur_col;
      ctl_next.valid      = 1'b1;
      ctl_next.emit_main  = (cur_row != '0) && (cur_col != '0);
      ctl_next.emit_right = (cur_row != '0) && (cur_col == w_m1);
      ctl_next.top        = (cur_row == HEIGHT_BITS'(1));
      ctl_next.left       = (cur_col == AW'(1));
      ctl_next.capture    = (cur_row == h_m1) && (cur_col == '0);
      pending_next        = 1'b0;
      if (cur_col == w_m1) begin
        col_next = '0;
        if (cur_row == h_m1) begin
          row_next       = '0;
          pending_next   = 1'b1;
          flush_col_next = '0;
        end else begin
          row_next = cur_row + HEIGHT_BITS'(1);
        end
      end else begin
        col_next = cur_col + AW'(1);
        row_next = cur_row;
      end
    end else begin
      ctl_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      pad_mode     <= RST_PAD_MODE;
      pad_value    <= RST_PAD_VALUE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_PAD_MODE:     pad_mode     <= cfg_data[0];
        REG_PAD_VALUE:    pad_value    <= cfg_data[PAD_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      flush_col <= '0;
      pending   <= 1'b0;
      s1_ctl    <= '0;
    end else begin
      col       <= col_next;
      row       <= row_next;
      flush_col <= flush_col_next;
      pending   <= pending_next;
      s1_ctl    <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= rd_addr;
    s1_pix  <= in_pixel;
  end

endmodule

/* rtl/bm3_linebuf.sv */
// Two line stores holding the two previous rows, with registered read data.
// Each pixel rotates its column: upper takes the old lower, lower takes the pixel.
// Depends on bm3_pkg only through its parameter defaults.
module bm3_linebuf #(
  parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bm3_pkg::DEF_PIXEL_BITS,
  parameter int AW         = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [PIXEL_BITS-1:0] wr_pix,
  output logic [PIXEL_BITS-1:0] rd_upper,
  output logic [PIXEL_BITS-1:0] rd_lower
);

  logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= rd_lower;
    end
    if (rd_en) begin
      rd_upper <= upper_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lower_mem[wr_addr] <= wr_pix;
    end
    if (rd_en) begin
      rd_lower <= lower_mem[rd_addr];
    end
  end

endmodule

/* rtl/bm3_window.sv */
// 3x3 window, border padding, nine-term sums and the divide by nine.
// Takes the line store read data and produces up to two results per item.
// Depends on bm3_pkg.
module bm3_window #(
  parameter int PIXEL_BITS = bm3_pkg::DEF_PIXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bm3_pkg::item_ctl_t            s1_ctl,
  input  logic [PIXEL_BITS-1:0]         s1_pix,
  input  logic [PIXEL_BITS-1:0]         rd_upper,
  input  logic [PIXEL_BITS-1:0]         rd_lower,
  input  logic                          pad_mode,
  input  logic [bm3_pkg::PAD_BITS-1:0]  pad_value,
  output logic                          res0_valid,
  output bm3_pkg::result_t              res0,
  output logic                          res1_valid,
  output bm3_pkg::result_t              res1,
  output logic [2:0]                    inflight
);
  import bm3_pkg::*;

  localparam int PB    = PIXEL_BITS;
  localparam int SW    = PB + 4;
  localparam int SHIFT = PB + 7;
  localparam int KW    = PB + 4;
  localparam int PW    = SW + KW;
  localparam logic [KW-1:0] RECIP = KW'(((2 ** SHIFT) + 8) / 9);

  typedef logic [2:0][2:0][PB-1:0] grid_t;

  grid_t           win, win_next, right_grid;
  logic [1:0][PB-1:0] cap;
  logic [PB-1:0]   pad_pix;
  logic [SW-1:0]   main_sum, right_sum;
  logic [SW-1:0]   s2_main_sum, s2_right_sum;
  logic            s2_main_v, s2_right_v, s2_main_last, s2_eof;
  logic [PW-1:0]   main_prod, right_prod;

  function automatic logic [SW-1:0] grid_sum(
    input grid_t         g,
    input logic          pt,
    input logic          pb,
    input logic          pl,
    input logic          pr,
    input logic          mode,
    input logic [PB-1:0] padv
  );
    logic [SW-1:0] acc;
    int            si;
    int            sj;
    logic          pad;
    acc = '0;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        si = i;
        sj = j;
        if (pt && i == 0) si = 1;
        if (pb && i == 2) si = 1;
        if (pl && j == 0) sj = 1;
        if (pr && j == 2) sj = 1;
        pad = (si != i) || (sj != j);
        if (pad && (mode == PAD_CONSTANT)) begin
          acc = acc + SW'(padv);
        end else begin
          acc = acc + SW'(g[sj][si]);
        end
      end
    end
    return acc;
  endfunction

  assign pad_pix = PB'(pad_value);

  always_comb begin
    win_next = win;
    if (s1_ctl.valid) begin
      win_next[0] = win[1];
      win_next[1] = win[2];
      if (s1_ctl.flush && s1_ctl.first) begin
        win_next[1][0] = cap[0];
        win_next[1][1] = cap[1];
        win_next[1][2] = '0;
      end
      win_next[2][0] = rd_upper;
      win_next[2][1] = rd_lower;
      win_next[2][2] = s1_ctl.flush ? '0 : s1_pix;
    end
    right_grid    = '0;
    right_grid[0] = win_next[1];
    right_grid[1] = win_next[2];
    main_sum  = grid_sum(win_next, s1_ctl.top, s1_ctl.flush, s1_ctl.left, s1_ctl.right,
                         pad_mode, pad_pix);
    right_sum = grid_sum(right_grid, s1_ctl.top, 1'b0, 1'b0, 1'b1, pad_mode, pad_pix);
  end

  always_ff @(posedge clk) begin
    win          <= win_next;
    s2_main_sum  <= main_sum;
    s2_right_sum <= right_sum;
    s2_main_last <= ~s1_ctl.emit_right;
    s2_eof       <= s1_ctl.eof;
    if (s1_ctl.valid && s1_ctl.capture) begin
      cap[0] <= rd_lower;
      cap[1] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_main_v  <= 1'b0;
      s2_right_v <= 1'b0;
    end else begin
      s2_main_v  <= s1_ctl.valid & s1_ctl.emit_main;
      s2_right_v <= s1_ctl.valid & s1_ctl.emit_right;
    end
  end

  assign main_prod  = PW'(s2_main_sum) * PW'(RECIP);
  assign right_prod = PW'(s2_right_sum) * PW'(RECIP);

  assign res0_valid = s2_main_v;
  assign res0.eof   = s2_eof;
  assign res0.last  = s2_main_last;
  assign res0.mean  = MEAN_BITS'(main_prod[SHIFT +: PB]);
  assign res1_valid = s2_right_v;
  assign res1.eof   = 1'b0;
  assign res1.last  = 1'b1;
  assign res1.mean  = MEAN_BITS'(right_prod[SHIFT +: PB]);

  assign inflight = 3'(s1_ctl.valid & s1_ctl.emit_main) +
                    3'(s1_ctl.valid & s1_ctl.emit_right) +
                    3'(s2_main_v) + 3'(s2_right_v);

endmodule

/* rtl/bm3_outq.sv */
// Result queue that takes up to two results a cycle and drains one on out_ready.
// Grants input credit from its fill level plus results still in the pipeline.
// Depends on bm3_pkg.
module bm3_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in0_valid,
  input  bm3_pkg::result_t in0,
  input  logic             in1_valid,
  input  bm3_pkg::result_t in1,
  input  logic [2:0]       inflight,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output bm3_pkg::result_t out_data
);
  import bm3_pkg::*;

  result_t                   entries [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [OUT_COUNT_BITS-1:0] count;
  logic                      pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid & out_ready;
  assign room      = (int'(count) + int'(inflight) + 2) <= OUT_DEPTH;

  always_ff @(posedge clk) begin
    if (in0_valid) begin
      entries[wr_ptr] <= in0;
    end
    if (in1_valid) begin
      entries[wr_ptr + OUT_PTR_BITS'(in0_valid)] <= in1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_BITS'(in0_valid) + OUT_PTR_BITS'(in1_valid);
      rd_ptr <= rd_ptr + OUT_PTR_BITS'(pop);
      count  <= count + OUT_COUNT_BITS'(in0_valid) + OUT_COUNT_BITS'(in1_valid)
                - OUT_COUNT_BITS'(pop);
    end
  end

endmodule

/* rtl/box_mean_3x3_padded.sv */
// 3x3 box-mean filter with a one-pixel border, constant or edge-replicated.
// Pixels arrive in row order, one request per clock while s_tready is high, with no gaps
// required; the result for row R comes out while row R+1 streams in, and flush requests
// (one per column) finish the last row. Past the first row, a pixel at the last column
// yields two results and one at column 0 none, so a steady stream of output runs at W
// results per W pixels. An accepted request passes the line store read, then the window
// and sums, then the divide into the eight-entry output queue. s_tready drops only when
// that queue plus the results in flight could not take two more. The line stores need no
// clearing after reset.
// Depends on bm3_pkg, bm3_ctrl, bm3_linebuf, bm3_window and bm3_outq.
module box_mean_3x3_padded #(
  parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bm3_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,   // pixel, zero fill above
  input  logic                                  s_tuser,   // command
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [bm3_pkg::MEAN_BITS-1:0]         m_tdata,   // mean_pixel
  output logic                                  m_tlast,   // last_of_run
  output logic                                  m_tuser,   // end_of_frame
  input  logic                                  cfg_write,
  input  logic [bm3_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [bm3_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import bm3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic                  room;
  logic                  pad_mode;
  logic [PAD_BITS-1:0]   pad_value;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  item_ctl_t             s1_ctl;
  logic [AW-1:0]         s1_addr;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [PIXEL_BITS-1:0] rd_upper, rd_lower;
  logic                  res0_valid, res1_valid;
  result_t               res0, res1, out_data;
  logic [2:0]            inflight;

  bm3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (cmd_e'(s_tuser)),
    .in_pixel   (s_tdata[PIXEL_BITS-1:0]),
    .room       (room),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_reg_e'(cfg_index)),
    .cfg_data   (cfg_data),
    .pad_mode   (pad_mode),
    .pad_value  (pad_value),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s1_ctl     (s1_ctl),
    .s1_addr    (s1_addr),
    .s1_pix     (s1_pix)
  );

  bm3_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW)
  ) u_linebuf (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (s1_ctl.valid & ~s1_ctl.flush),
    .wr_addr  (s1_addr),
    .wr_pix   (s1_pix),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower)
  );

  bm3_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .s1_ctl     (s1_ctl),
    .s1_pix     (s1_pix),
    .rd_upper   (rd_upper),
    .rd_lower   (rd_lower),
    .pad_mode   (pad_mode),
    .pad_value  (pad_value),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1),
    .inflight   (inflight)
  );

  bm3_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in0_valid (res0_valid),
    .in0       (res0),
    .in1_valid (res1_valid),
    .in1       (res1),
    .inflight  (inflight),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data.mean;
  assign m_tlast = out_data.last;
  assign m_tuser = out_data.eof;

endmodule
